@@ design/dvc_pkg.sv @@
package dvc_pkg;

    localparam int STORE_DEPTH = 128;
    localparam int VALUE_BITS  = 32;

    localparam int DATA_W      = 32;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int TOTAL_W     = 16;
    localparam int DCNT_OUT_W  = 8;
    localparam int CMP_W       = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [CNT_W-1:0]   STORE_FULL = CNT_W'(STORE_DEPTH);

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } dvc_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_busy;
    } dvc_status_t;

endpackage

@@ design/dvc_ram.sv @@
module dvc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/dvc_ctrl.sv @@
module dvc_ctrl
    import dvc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  dvc_status_t status,
    output dvc_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // The result register must be free before the store and counts move on.
                if (!status.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ design/dvc_datapath.sv @@
module dvc_datapath
    import dvc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dvc_cmd_t                 cmd,
    output dvc_status_t              status,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     last,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] echo_value,
    output logic                     first_seen,
    output logic [DCNT_OUT_W-1:0]    distinct_count,
    output logic [TOTAL_W-1:0]       total_count,
    output logic [TOTAL_W-1:0]       duplicate_count,
    output logic                     all_distinct,
    output logic                     all_same,
    output logic                     overflow,
    output logic                     end_of_run
);

    // Item being worked on.
    logic [DATA_W-1:0]     value_reg;
    logic                  last_reg;

    // Run state.
    logic [CNT_W-1:0]      distinct_reg, distinct_next;
    logic [TOTAL_W-1:0]    total_reg, total_next;
    logic                  ovf_reg, ovf_next;

    // Scan state.
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic                  found_reg, found_next;

    // Result register.
    logic                  out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]     echo_reg;
    logic                  first_reg;
    logic [DCNT_OUT_W-1:0] dcnt_reg;
    logic [TOTAL_W-1:0]    tcnt_reg;
    logic [TOTAL_W-1:0]    dup_reg;
    logic                  all_d_reg;
    logic                  all_s_reg;
    logic                  ovf_out_reg;
    logic                  eor_reg;

    logic [VALUE_BITS-1:0] key;
    logic [VALUE_BITS-1:0] ram_rdata;
    logic                  issue;
    logic                  hit;
    logic                  is_new;
    logic                  store_full;
    logic                  do_write;
    logic [CNT_W-1:0]      dist_upd;
    logic [TOTAL_W-1:0]    total_upd;
    logic                  ovf_upd;
    logic [CMP_W-1:0]      dist_cmp;
    logic [CMP_W-1:0]      total_cmp;
    logic [TOTAL_W-1:0]    dup_val;
    logic                  all_d_val;
    logic                  all_s_val;

    assign key   = value_reg[VALUE_BITS-1:0];
    assign hit   = cmp_valid_reg && (ram_rdata == key);
    assign issue = cmd.scan && !found_reg && !hit && (idx_reg < distinct_reg);

    assign status.scan_done = found_reg || hit || ((idx_reg >= distinct_reg) && !cmp_valid_reg);
    assign status.out_busy  = out_valid_reg && !out_ready;

    // Outcome of the item, used when it is committed.
    assign is_new     = !found_reg;
    assign store_full = (distinct_reg == STORE_FULL);
    assign do_write   = cmd.commit && is_new && !store_full;
    assign dist_upd   = distinct_reg + CNT_W'(is_new && !store_full);
    assign ovf_upd    = ovf_reg || (is_new && store_full);
    assign total_upd  = (total_reg == TOTAL_MAX) ? total_reg : total_reg + TOTAL_W'(1);
    assign dist_cmp   = CMP_W'(dist_upd);
    assign total_cmp  = CMP_W'(total_upd);

    always_comb
    begin
        dup_val   = '0;
        all_d_val = 1'b0;
        all_s_val = 1'b0;
        if (last_reg)
        begin
            if (total_cmp >= dist_cmp)
            begin
                dup_val = TOTAL_W'(total_cmp - dist_cmp);
            end
            all_d_val = (dist_cmp == total_cmp);
            all_s_val = (dist_upd == CNT_W'(1)) && !all_d_val;
        end
    end

    dvc_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (do_write),
        .waddr (distinct_reg[ADDR_W-1:0]),
        .wdata (key),
        .re    (issue),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        idx_next       = idx_reg;
        cmp_valid_next = cmp_valid_reg;
        found_next     = found_reg;
        distinct_next  = distinct_reg;
        total_next     = total_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.load)
        begin
            idx_next       = '0;
            cmp_valid_next = 1'b0;
            found_next     = 1'b0;
        end
        else if (cmd.scan)
        begin
            // Read data arrives in the cycle after the address, so compare lags issue.
            cmp_valid_next = issue;
            found_next     = found_reg || hit;
            if (issue)
            begin
                idx_next = idx_reg + CNT_W'(1);
            end
        end

        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
            if (last_reg)
            begin
                distinct_next = '0;
                total_next    = '0;
                ovf_next      = 1'b0;
            end
            else
            begin
                distinct_next = dist_upd;
                total_next    = total_upd;
                ovf_next      = ovf_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            distinct_reg  <= '0;
            total_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            cmp_valid_reg <= cmp_valid_next;
            found_reg     <= found_next;
            distinct_reg  <= distinct_next;
            total_reg     <= total_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg <= value;
            last_reg  <= last;
        end
        if (cmd.commit)
        begin
            echo_reg    <= value_reg;
            first_reg   <= is_new;
            dcnt_reg    <= DCNT_OUT_W'(dist_upd);
            tcnt_reg    <= total_upd;
            dup_reg     <= dup_val;
            all_d_reg   <= all_d_val;
            all_s_reg   <= all_s_val;
            ovf_out_reg <= ovf_upd;
            eor_reg     <= last_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign echo_value      = echo_reg;
    assign first_seen      = first_reg;
    assign distinct_count  = dcnt_reg;
    assign total_count     = tcnt_reg;
    assign duplicate_count = dup_reg;
    assign all_distinct    = all_d_reg;
    assign all_same        = all_s_reg;
    assign overflow        = ovf_out_reg;
    assign end_of_run      = eor_reg;

endmodule

@@ design/distinct_value_counter.sv @@
// Counts distinct values in runs of signed 32-bit items, one result per item, with last
// closing a run and clearing all counts. Each item is compared against the values already
// stored in this run through the single read port of the value store, one entry per cycle.
// A new value arriving with the store full is reported as first seen, is not stored,
// and sets the sticky overflow flag for the rest of the run. The total count saturates
// at 65535. The next item is taken while a finished result still waits in the output
// register.
module distinct_value_counter
    import dvc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     last,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] echo_value,
    output logic                     first_seen,
    output logic [DCNT_OUT_W-1:0]    distinct_count,
    output logic [TOTAL_W-1:0]       total_count,
    output logic [TOTAL_W-1:0]       duplicate_count,
    output logic                     all_distinct,
    output logic                     all_same,
    output logic                     overflow,
    output logic                     end_of_run
);

    dvc_cmd_t    cmd;
    dvc_status_t status;

    dvc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    dvc_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .value           (value),
        .last            (last),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .echo_value      (echo_value),
        .first_seen      (first_seen),
        .distinct_count  (distinct_count),
        .total_count     (total_count),
        .duplicate_count (duplicate_count),
        .all_distinct    (all_distinct),
        .all_same        (all_same),
        .overflow        (overflow),
        .end_of_run      (end_of_run)
    );

endmodule
